@@ rtl/rra_pkg.sv @@
// Shared types, constants and helper functions of the rectangle region allocator.
// Used by the sequencer core and by the top level; no dependencies of its own.
package rra_pkg;

	// Table geometry.
	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	// Merge neighbor list.
	localparam int ADJ_MAX = 4;
	localparam int ADJ_W   = $clog2(ADJ_MAX + 1);
	localparam int ADJ_IW  = $clog2(ADJ_MAX);

	// Field widths.
	localparam int ID_W   = 16;
	localparam int DIM_W  = 15;
	localparam int POS_W  = 16;
	localparam int OFS_W  = 14;
	localparam int AREA_W = 2 * DIM_W;

	localparam logic [DIM_W-1:0] DIM_MAX   = 15'd16384;
	localparam logic [DIM_W-1:0] DIM_RESET = 15'd1024;
	localparam logic [DIM_W:0]   SLACK     = 16'd2;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_ATLAS_W = 1'b0;
	localparam logic CFG_ATLAS_H = 1'b1;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_NOFIT = 2'd1,
		STS_FULL  = 2'd2,
		STS_NOID  = 2'd3
	} status_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic [ID_W-1:0]  owner;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Table memory access from the core.
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	// Atlas size and the reinitialize strobe.
	typedef struct packed {
		logic [DIM_W-1:0] atlas_w;
		logic [DIM_W-1:0] atlas_h;
		logic             reinit;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [OFS_W-1:0] x;
		logic [OFS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} result_t;

	// Saturate a grown dimension at the largest atlas side.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W:0] v);
		logic [DIM_W-1:0] r;
		r = (v > {1'b0, DIM_MAX}) ? DIM_MAX : v[DIM_W-1:0];
		return r;
	endfunction

	function automatic rect_t ent_rect(input entry_t e);
		rect_t r;
		r.x = e.x;
		r.y = e.y;
		r.w = e.w;
		r.h = e.h;
		return r;
	endfunction

	// True when rectangle p shares a full edge with rectangle m.
	function automatic logic touches(input rect_t p, input rect_t m);
		logic [POS_W:0] pxe;
		logic [POS_W:0] pye;
		logic [POS_W:0] mxe;
		logic [POS_W:0] mye;
		logic           r;
		pxe = {1'b0, p.x} + {2'b00, p.w};
		pye = {1'b0, p.y} + {2'b00, p.h};
		mxe = {1'b0, m.x} + {2'b00, m.w};
		mye = {1'b0, m.y} + {2'b00, m.h};
		if (pxe == {1'b0, m.x} || {1'b0, p.x} == mxe) begin
			r = (p.y == m.y) && (p.h == m.h);
		end else if (pye == {1'b0, m.y} || {1'b0, p.y} == mye) begin
			r = (p.x == m.x) && (p.w == m.w);
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ rtl/rra_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module rra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address being written returns the old data; read data is registered and appears in the cycle after re.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/rra_core.sv @@
// Sequencer of the rectangle region allocator: scans, splits, merges and compacts
// the rectangle table held in the external RAM. Depends on rra_pkg.
module rra_core import rra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [ID_W-1:0]  texture_id,
	input  logic [DIM_W-1:0] req_width,
	input  logic [DIM_W-1:0] req_height,
	output ram_req_t         ram_req,
	input  entry_t           ram_rdata,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_ASCAN  = 10'b0000000010,
		S_AFIT   = 10'b0000000100,
		S_ARIGHT = 10'b0000001000,
		S_ABOT   = 10'b0000010000,
		S_FFIND  = 10'b0000100000,
		S_FADJ   = 10'b0001000000,
		S_FMERGE = 10'b0010000000,
		S_FPACK  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t            state_q;
	logic              init_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rd_q;
	logic [CNT_W-1:0]  k_q;
	logic              found_q;
	logic [ADJ_W-1:0]  nadj_q;
	logic [ADJ_W-1:0]  mj_q;

	// Read pipeline: stage 1 is RAM output, stage 2 holds the area product.
	logic              rv_s1;
	logic [IDX_W-1:0]  ri_s1;
	logic              v_s2;
	logic              fit_s2;
	logic [AREA_W-1:0] area_s2;
	entry_t            e_s2;
	logic [IDX_W-1:0]  i_s2;

	logic [ID_W-1:0]   id_q;
	logic [DIM_W-1:0]  rw_q;
	logic [DIM_W-1:0]  rh_q;
	entry_t            best_q;
	logic [AREA_W-1:0] best_area_q;
	logic [IDX_W-1:0]  bidx_q;
	rect_t             node_q;
	logic [IDX_W-1:0]  nidx_q;
	rect_t             cur_q;
	rect_t             adj_q [ADJ_MAX];
	logic [IDX_W-1:0]  adj_idx_q [ADJ_MAX];
	result_t           res_q;

	logic              accept;
	logic              issue;
	logic              bad_size;
	logic              fit1;
	logic [AREA_W-1:0] area1;
	logic              better;
	logic              scan_a_done;
	logic              find_hit;
	logic              find_done;
	logic              adj_hit;
	logic              adj_done;
	logic              pack_done;
	logic              gone;
	logic              split;
	logic              full;
	logic              right_wide;
	logic [DIM_W-1:0]  sx;
	logic [DIM_W-1:0]  sy;
	logic [CNT_W-1:0]  need;
	rect_t             adj_sel;
	rect_t             merged;
	entry_t            right_e;
	entry_t            bot_e;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || init_q;

	// Read issue for the four table passes.
	always_comb begin
		case (state_q)
			S_ASCAN, S_FPACK: issue = rd_q < cnt_q;
			S_FFIND:          issue = (rd_q < cnt_q) && !found_q;
			S_FADJ:           issue = (rd_q < cnt_q) && (nadj_q < ADJ_W'(ADJ_MAX));
			default:          issue = 1'b0;
		endcase
	end

	assign bad_size = (req_width == '0) || (req_height == '0) ||
		(req_width > cfg.atlas_w) || (req_height > cfg.atlas_h);

	// Best area fit pass.
	assign fit1  = (ram_rdata.owner == '0) && (ram_rdata.w >= rw_q) && (ram_rdata.h >= rh_q);
	assign area1 = AREA_W'(ram_rdata.w) * AREA_W'(ram_rdata.h);
	assign better = v_s2 && fit_s2 && (!found_q || (area_s2 < best_area_q));
	assign scan_a_done = (rd_q >= cnt_q) && !rv_s1 && !v_s2;

	// Lookup and neighbor passes.
	assign find_hit  = rv_s1 && !found_q && (ram_rdata.owner == id_q);
	assign find_done = (found_q || (rd_q >= cnt_q)) && !rv_s1;
	assign adj_hit   = rv_s1 && (nadj_q < ADJ_W'(ADJ_MAX)) && (ri_s1 != nidx_q) &&
		(ram_rdata.owner == '0) && touches(ent_rect(ram_rdata), node_q);
	assign adj_done  = ((rd_q >= cnt_q) || (nadj_q == ADJ_W'(ADJ_MAX))) && !rv_s1;
	assign pack_done = (rd_q >= cnt_q) && !rv_s1;

	// Entries absorbed by the merge are dropped during compaction.
	always_comb begin
		gone = 1'b0;
		for (int j = 0; j < ADJ_MAX; j++) begin
			if ((ADJ_W'(j) < nadj_q) && (adj_idx_q[j] == ri_s1)) begin
				gone = 1'b1;
			end
		end
	end

	// Split decision on the chosen rectangle.
	assign sx         = best_q.w - rw_q;
	assign sy         = best_q.h - rh_q;
	assign split      = ({1'b0, best_q.w} > ({1'b0, rw_q} + SLACK)) ||
		({1'b0, best_q.h} > ({1'b0, rh_q} + SLACK));
	assign need       = CNT_W'(sx != '0) + CNT_W'(sy != '0);
	assign full       = split &&
		(({1'b0, cnt_q} + {1'b0, need}) > (CNT_W + 1)'(MAX_ENTRIES));
	assign right_wide = sx > sy;

	always_comb begin
		right_e.owner = '0;
		right_e.x     = best_q.x + POS_W'(rw_q);
		right_e.y     = best_q.y;
		right_e.w     = sx;
		right_e.h     = right_wide ? best_q.h : rh_q;
		bot_e.owner   = '0;
		bot_e.x       = best_q.x;
		bot_e.y       = best_q.y + POS_W'(rh_q);
		bot_e.w       = right_wide ? rw_q : best_q.w;
		bot_e.h       = sy;
	end

	// One neighbor folded into the freed rectangle per cycle.
	assign adj_sel = adj_q[mj_q[ADJ_IW-1:0]];
	always_comb begin
		merged = cur_q;
		if (adj_sel.x < cur_q.x) begin
			merged.x = adj_sel.x;
			merged.w = sat_dim({1'b0, cur_q.w} + {1'b0, adj_sel.w});
		end else if (adj_sel.x > cur_q.x) begin
			merged.w = sat_dim({1'b0, cur_q.w} + {1'b0, adj_sel.w});
		end else if (adj_sel.y < cur_q.y) begin
			merged.y = adj_sel.y;
			merged.h = sat_dim({1'b0, cur_q.h} + {1'b0, adj_sel.h});
		end else if (adj_sel.y > cur_q.y) begin
			merged.h = sat_dim({1'b0, cur_q.h} + {1'b0, adj_sel.h});
		end
	end

	// Table memory requests.
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = '0;
		ram_req.wdata = '0;
		ram_req.re    = issue;
		ram_req.raddr = rd_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (init_q) begin
					ram_req.we      = 1'b1;
					ram_req.wdata.w = cfg.atlas_w;
					ram_req.wdata.h = cfg.atlas_h;
				end
			end
			S_AFIT: begin
				if (!full) begin
					ram_req.we          = 1'b1;
					ram_req.waddr       = bidx_q;
					ram_req.wdata.owner = id_q;
					ram_req.wdata.x     = best_q.x;
					ram_req.wdata.y     = best_q.y;
					ram_req.wdata.w     = split ? rw_q : best_q.w;
					ram_req.wdata.h     = split ? rh_q : best_q.h;
				end
			end
			S_ARIGHT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q[IDX_W-1:0];
				ram_req.wdata = right_e;
			end
			S_ABOT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = cnt_q[IDX_W-1:0];
				ram_req.wdata = bot_e;
			end
			S_FPACK: begin
				if (rv_s1 && !gone) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = k_q[IDX_W-1:0];
					if (ri_s1 == nidx_q) begin
						ram_req.wdata = {{ID_W{1'b0}}, cur_q};
					end else begin
						ram_req.wdata = ram_rdata;
					end
				end
			end
			default: begin
				ram_req.we = 1'b0;
			end
		endcase
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			init_q  <= 1'b1;
			cnt_q   <= CNT_W'(1);
			rd_q    <= '0;
			k_q     <= '0;
			found_q <= 1'b0;
			nadj_q  <= '0;
			mj_q    <= '0;
			rv_s1   <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			rv_s1 <= issue;
			v_s2  <= rv_s1 && (state_q == S_ASCAN);
			if (issue) begin
				rd_q <= rd_q + CNT_W'(1);
			end
			if (cfg.reinit) begin
				init_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				init_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (init_q) begin
						cnt_q <= CNT_W'(1);
					end
					if (accept) begin
						rd_q    <= '0;
						found_q <= 1'b0;
						nadj_q  <= '0;
						if (texture_id == '0) begin
							state_q <= S_DONE;
						end else if (operation == OP_FREE) begin
							state_q <= S_FFIND;
						end else if (bad_size) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_ASCAN;
						end
					end
				end
				S_ASCAN: begin
					if (better) begin
						found_q <= 1'b1;
					end
					if (scan_a_done) begin
						state_q <= found_q ? S_AFIT : S_DONE;
					end
				end
				S_AFIT: begin
					if (!split || full) begin
						state_q <= S_DONE;
					end else if (sx != '0) begin
						state_q <= S_ARIGHT;
					end else begin
						state_q <= S_ABOT;
					end
				end
				S_ARIGHT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= (sy != '0) ? S_ABOT : S_DONE;
				end
				S_ABOT: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_DONE;
				end
				S_FFIND: begin
					if (find_hit) begin
						found_q <= 1'b1;
					end
					if (find_done) begin
						rd_q    <= '0;
						state_q <= found_q ? S_FADJ : S_DONE;
					end
				end
				S_FADJ: begin
					if (adj_hit) begin
						nadj_q <= nadj_q + ADJ_W'(1);
					end
					if (adj_done) begin
						mj_q    <= '0;
						state_q <= S_FMERGE;
					end
				end
				S_FMERGE: begin
					if (mj_q < nadj_q) begin
						mj_q <= mj_q + ADJ_W'(1);
					end else begin
						rd_q    <= '0;
						k_q     <= '0;
						state_q <= S_FPACK;
					end
				end
				S_FPACK: begin
					if (rv_s1 && !gone) begin
						k_q <= k_q + CNT_W'(1);
					end
					if (pack_done) begin
						cnt_q   <= k_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working data and result.
	always_ff @(posedge clk) begin
		ri_s1   <= rd_q[IDX_W-1:0];
		fit_s2  <= fit1;
		area_s2 <= area1;
		e_s2    <= ram_rdata;
		i_s2    <= ri_s1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					id_q    <= texture_id;
					rw_q    <= req_width;
					rh_q    <= req_height;
					res_q.x <= '0;
					res_q.y <= '0;
					res_q.w <= '0;
					res_q.h <= '0;
					if (texture_id == '0) begin
						res_q.status <= STS_NOID;
					end else if ((operation == OP_ALLOC) && bad_size) begin
						res_q.status <= STS_NOFIT;
					end else begin
						res_q.status <= STS_OK;
					end
				end
			end
			S_ASCAN: begin
				if (better) begin
					best_q      <= e_s2;
					bidx_q      <= i_s2;
					best_area_q <= area_s2;
				end
				if (scan_a_done && !found_q) begin
					res_q.status <= STS_NOFIT;
				end
			end
			S_AFIT: begin
				if (full) begin
					res_q.status <= STS_FULL;
				end else begin
					res_q.x <= best_q.x[OFS_W-1:0];
					res_q.y <= best_q.y[OFS_W-1:0];
					res_q.w <= split ? rw_q : best_q.w;
					res_q.h <= split ? rh_q : best_q.h;
				end
			end
			S_FFIND: begin
				if (find_hit) begin
					node_q <= ent_rect(ram_rdata);
					cur_q  <= ent_rect(ram_rdata);
					nidx_q <= ri_s1;
				end
				if (find_done && !found_q) begin
					res_q.status <= STS_NOID;
				end
			end
			S_FADJ: begin
				if (adj_hit) begin
					adj_q[nadj_q[ADJ_IW-1:0]]     <= ent_rect(ram_rdata);
					adj_idx_q[nadj_q[ADJ_IW-1:0]] <= ri_s1;
				end
			end
			S_FMERGE: begin
				if (mj_q < nadj_q) begin
					cur_q <= merged;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign res_valid = (state_q == S_DONE) && res_ready;
	assign res       = res_q;

endmodule

@@ rtl/rectangle_region_allocator_top.sv @@
// Rectangle region allocator for a 2D texture atlas: configuration registers,
// output register and the table RAM around the sequencer core.
// Depends on rra_pkg, rra_ram and rra_core.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one request transaction: operation
//   0 allocates req_width x req_height for texture_id, operation 1 frees the
//   rectangle owned by texture_id.
// - Output channel (out_valid/out_stall) returns exactly one result transaction
//   per request, in order: status, offset and granted size.
// - Requests are handled one at a time. An allocate makes one table read pass plus
//   up to three writes; a free makes lookup, neighbor and compaction passes over
//   the single read port of the table RAM, plus up to four merge steps.
// - A finished result sits in the output register; the next request is accepted
//   while it waits. If the receiver keeps stalling, the following result is held
//   in the core and in_stall stays high until the register frees up.
// - Reset sets the atlas to 1024 x 1024 and writes the single free rectangle
//   into the table; a write to atlas_width or atlas_height does the same with the
//   new size. Write configuration only while idle.
module rectangle_region_allocator_top import rra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [ID_W-1:0]  texture_id,
	input  logic [DIM_W-1:0] req_width,
	input  logic [DIM_W-1:0] req_height,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [OFS_W-1:0] offset_x,
	output logic [OFS_W-1:0] offset_y,
	output logic [DIM_W-1:0] grant_width,
	output logic [DIM_W-1:0] grant_height
);

	logic [DIM_W-1:0] atlas_w_q;
	logic [DIM_W-1:0] atlas_h_q;
	logic [DIM_W-1:0] cfg_sat;
	cfg_t             cfg;
	ram_req_t         ram_req;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	entry_t           ram_rdata;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	// Configuration registers; oversized sides clamp to the largest atlas.
	assign cfg_sat = (cfg_wdata > DIM_MAX) ? DIM_MAX : cfg_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q <= DIM_RESET;
			atlas_h_q <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ATLAS_W: atlas_w_q <= cfg_sat;
				CFG_ATLAS_H: atlas_h_q <= cfg_sat;
				default:     atlas_w_q <= atlas_w_q;
			endcase
		end
	end

	assign cfg.atlas_w = atlas_w_q;
	assign cfg.atlas_h = atlas_h_q;
	assign cfg.reinit  = cfg_we;

	// Rectangle table.
	rra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	rra_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.texture_id (texture_id),
		.req_width  (req_width),
		.req_height (req_height),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register between the core and the receiver.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign offset_x     = out_q.x;
	assign offset_y     = out_q.y;
	assign grant_width  = out_q.w;
	assign grant_height = out_q.h;

	// A failed request never reports a rectangle.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STS_OK)) |->
		((offset_x == '0) && (offset_y == '0) && (grant_width == '0) && (grant_height == '0)))
		else $error("failed request reports a rectangle");

	// A granted rectangle has both sides nonzero.
	a_grant_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STS_OK) && (grant_width != '0)) |-> (grant_height != '0))
		else $error("granted rectangle with zero height");

	// A configuration write holds off requests while the table is rebuilt.
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("request accepted during table reinitialization");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the rectangle region allocator top level.
// Depends on rra_pkg and the allocator RTL; holds its own table predictor.
module tb;
	import rra_pkg::*;

	typedef struct {
		logic             op;
		logic [ID_W-1:0]  id;
		logic [DIM_W-1:0] rw;
		logic [DIM_W-1:0] rh;
	} request_t;

	typedef struct {
		logic [1:0]       status;
		logic [OFS_W-1:0] ox;
		logic [OFS_W-1:0] oy;
		logic [DIM_W-1:0] gw;
		logic [DIM_W-1:0] gh;
	} grant_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [DIM_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_stall;
	logic             operation;
	logic [ID_W-1:0]  texture_id;
	logic [DIM_W-1:0] req_width;
	logic [DIM_W-1:0] req_height;
	logic             out_valid;
	logic             out_stall;
	logic [1:0]       status;
	logic [OFS_W-1:0] offset_x;
	logic [OFS_W-1:0] offset_y;
	logic [DIM_W-1:0] grant_width;
	logic [DIM_W-1:0] grant_height;

	request_t    pending_q[$];
	grant_t      grant_q[$];
	int unsigned issued_cnt;
	int unsigned accepted_cnt;
	int unsigned err_cnt;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	logic        in_taken;

	// Predicted atlas table.
	int unsigned atlas_w, atlas_h;
	int unsigned ent_owner[MAX_ENTRIES];
	int unsigned ent_x[MAX_ENTRIES];
	int unsigned ent_y[MAX_ENTRIES];
	int unsigned ent_w[MAX_ENTRIES];
	int unsigned ent_h[MAX_ENTRIES];
	int unsigned ent_cnt;
	int unsigned live_ids[$];

	rectangle_region_allocator_top u_top (.*);

	// Clock with period 8.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int unsigned clamp_dim(int unsigned v);
		return (v > 16384) ? 16384 : v;
	endfunction

	function automatic void table_reinit();
		ent_cnt = 1;
		ent_owner[0] = 0;
		ent_x[0] = 0;
		ent_y[0] = 0;
		ent_w[0] = atlas_w;
		ent_h[0] = atlas_h;
	endfunction

	function automatic void append_free_rect(int unsigned x, int unsigned y,
			int unsigned w, int unsigned h);
		ent_owner[ent_cnt] = 0;
		ent_x[ent_cnt] = x;
		ent_y[ent_cnt] = y;
		ent_w[ent_cnt] = w;
		ent_h[ent_cnt] = h;
		ent_cnt++;
	endfunction

	function automatic bit shares_edge(int unsigned k, int unsigned mx, int unsigned my,
			int unsigned mw, int unsigned mh);
		if (ent_x[k] + ent_w[k] == mx || ent_x[k] == mx + mw)
			return ent_y[k] == my && ent_h[k] == mh;
		if (ent_y[k] + ent_h[k] == my || ent_y[k] == my + mh)
			return ent_x[k] == mx && ent_w[k] == mw;
		return 0;
	endfunction

	// Allocate: best area fit, then guillotine split when slack exceeds two.
	function automatic grant_t place_rect(int unsigned id, int unsigned rw, int unsigned rh);
		grant_t      g;
		int unsigned best, best_area, area, x, y, w, h, sx, sy, need;
		bit          found, right_wide;
		g = '{STS_OK, 0, 0, 0, 0};
		best = 0;
		best_area = 32'hFFFF_FFFF;
		found = 0;
		if (id == 0) begin
			g.status = STS_NOID;
			return g;
		end
		if (rw == 0 || rh == 0 || rw > atlas_w || rh > atlas_h) begin
			g.status = STS_NOFIT;
			return g;
		end
		for (int i = 0; i < ent_cnt; i++) begin
			if (ent_owner[i] != 0 || ent_w[i] < rw || ent_h[i] < rh)
				continue;
			area = ent_w[i] * ent_h[i];
			if (area < best_area) begin
				best_area = area;
				best = i;
				found = 1;
			end
		end
		if (!found) begin
			g.status = STS_NOFIT;
			return g;
		end
		x = ent_x[best];
		y = ent_y[best];
		w = ent_w[best];
		h = ent_h[best];
		if (w > rw + 2 || h > rh + 2) begin
			sx = w - rw;
			sy = h - rh;
			need = (sx != 0) + (sy != 0);
			right_wide = sx > sy;
			if (ent_cnt + need > MAX_ENTRIES) begin
				g.status = STS_FULL;
				return g;
			end
			if (sx != 0)
				append_free_rect(x + rw, y, sx, right_wide ? h : rh);
			if (sy != 0)
				append_free_rect(x, y + rh, right_wide ? rw : w, sy);
			ent_w[best] = rw;
			ent_h[best] = rh;
			w = rw;
			h = rh;
		end
		ent_owner[best] = id;
		g.ox = x[OFS_W-1:0];
		g.oy = y[OFS_W-1:0];
		g.gw = w[DIM_W-1:0];
		g.gh = h[DIM_W-1:0];
		return g;
	endfunction

	// Free: clear the owner, merge up to four free neighbors, compact the table.
	function automatic grant_t release_rect(int unsigned id);
		grant_t      g;
		int unsigned node, nadj, mx, my, mw, mh, a, k;
		int unsigned adj[ADJ_MAX];
		bit          gone[MAX_ENTRIES];
		bit          found;
		g = '{STS_NOID, 0, 0, 0, 0};
		node = 0;
		nadj = 0;
		found = 0;
		if (id == 0)
			return g;
		for (int i = 0; i < ent_cnt; i++) begin
			if (ent_owner[i] == id) begin
				node = i;
				found = 1;
				break;
			end
		end
		if (!found)
			return g;
		g.status = STS_OK;
		ent_owner[node] = 0;
		mx = ent_x[node];
		my = ent_y[node];
		mw = ent_w[node];
		mh = ent_h[node];
		for (int i = 0; i < MAX_ENTRIES; i++)
			gone[i] = 0;
		for (int i = 0; i < ent_cnt && nadj < ADJ_MAX; i++) begin
			if (i == node || ent_owner[i] != 0 || !shares_edge(i, mx, my, mw, mh))
				continue;
			adj[nadj++] = i;
		end
		for (int j = 0; j < nadj; j++) begin
			a = adj[j];
			if (ent_x[a] < ent_x[node]) begin
				ent_x[node] = ent_x[a];
				ent_w[node] = clamp_dim(ent_w[node] + ent_w[a]);
			end else if (ent_x[a] > ent_x[node]) begin
				ent_w[node] = clamp_dim(ent_w[node] + ent_w[a]);
			end else if (ent_y[a] < ent_y[node]) begin
				ent_y[node] = ent_y[a];
				ent_h[node] = clamp_dim(ent_h[node] + ent_h[a]);
			end else if (ent_y[a] > ent_y[node]) begin
				ent_h[node] = clamp_dim(ent_h[node] + ent_h[a]);
			end
			gone[a] = 1;
		end
		k = 0;
		for (int i = 0; i < ent_cnt; i++) begin
			if (gone[i])
				continue;
			ent_owner[k] = ent_owner[i];
			ent_x[k] = ent_x[i];
			ent_y[k] = ent_y[i];
			ent_w[k] = ent_w[i];
			ent_h[k] = ent_h[i];
			k++;
		end
		ent_cnt = k;
		return g;
	endfunction

	function automatic grant_t predict_grant(request_t r);
		if (r.op == OP_ALLOC)
			return place_rect(r.id, r.rw, r.rh);
		return release_rect(r.id);
	endfunction

	// Monitor: check result transactions, then predict newly accepted requests.
	always @(posedge clk) begin
		grant_t g;
		request_t r;
		if (out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				$error("result transaction with no request outstanding");
				err_cnt++;
			end else begin
				g = grant_q.pop_front();
				if (status !== g.status) begin
					$error("status: expected %0d, got %0d", g.status, status);
					err_cnt++;
				end
				if (offset_x !== g.ox) begin
					$error("offset_x: expected %0d, got %0d", g.ox, offset_x);
					err_cnt++;
				end
				if (offset_y !== g.oy) begin
					$error("offset_y: expected %0d, got %0d", g.oy, offset_y);
					err_cnt++;
				end
				if (grant_width !== g.gw) begin
					$error("grant_width: expected %0d, got %0d", g.gw, grant_width);
					err_cnt++;
				end
				if (grant_height !== g.gh) begin
					$error("grant_height: expected %0d, got %0d", g.gh, grant_height);
					err_cnt++;
				end
			end
		end
		in_taken = in_valid && !in_stall;
		if (in_taken) begin
			r = '{operation, texture_id, req_width, req_height};
			grant_q.push_back(predict_grant(r));
			accepted_cnt++;
		end
	end

	// Driver: present requests from the pending queue and stall the output at random.
	always @(negedge clk) begin
		request_t r;
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// Hold the stalled request.
			end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				r = pending_q.pop_front();
				in_valid <= 1'b1;
				operation <= r.op;
				texture_id <= r.id;
				req_width <= r.rw;
				req_height <= r.rh;
			end else begin
				in_valid <= 1'b0;
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic queue_req(logic op, int unsigned id, int unsigned rw, int unsigned rh);
		pending_q.push_back('{op, id[ID_W-1:0], rw[DIM_W-1:0], rh[DIM_W-1:0]});
		issued_cnt++;
	endtask

	task automatic drain();
		while (accepted_cnt != issued_cnt || grant_q.size() != 0)
			@(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, int unsigned value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[DIM_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ATLAS_W)
			atlas_w = clamp_dim(value & 32'h7FFF);
		else
			atlas_h = clamp_dim(value & 32'h7FFF);
		table_reinit();
		live_ids.delete();
	endtask

	// One random request: mostly well-formed allocates and frees of live ids.
	task automatic queue_random();
		int unsigned sel, id, rw, rh, pick;
		sel = $urandom_range(99);
		if (sel < 8) begin
			queue_req(1'($urandom_range(1)), $urandom_range(65535) * ($urandom_range(9) != 0),
				$urandom_range(32767), $urandom_range(32767));
		end else if (sel < 62) begin
			id = $urandom_range(65535, 1);
			if ($urandom_range(9) < 7) begin
				rw = $urandom_range((atlas_w > 8) ? atlas_w / 8 : 1, 1);
				rh = $urandom_range((atlas_h > 8) ? atlas_h / 8 : 1, 1);
			end else begin
				rw = $urandom_range(atlas_w + 3, 1);
				rh = $urandom_range(atlas_h + 3, 1);
			end
			queue_req(OP_ALLOC, id, rw, rh);
			live_ids.push_back(id);
		end else if (live_ids.size() > 0 && sel < 95) begin
			pick = $urandom_range(live_ids.size() - 1);
			queue_req(OP_FREE, live_ids[pick], $urandom_range(32767), $urandom_range(32767));
			live_ids.delete(pick);
		end else begin
			queue_req(OP_FREE, $urandom_range(65535, 1), 0, 0);
		end
	endtask

	// Stimulus sequence.
	initial begin
		int unsigned sizes_w[8] = '{1, 16384, 32767, 64, 200, 1024, 5, 3000};
		int unsigned sizes_h[8] = '{1, 16384, 20000, 64, 120, 1024, 7, 500};
		int unsigned send_mode[4] = '{0, 75, 0, 16};
		int unsigned stall_mode[4] = '{0, 0, 75, 16};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ATLAS_W;
		cfg_wdata = '0;
		in_valid = 1'b0;
		operation = OP_ALLOC;
		texture_id = '0;
		req_width = '0;
		req_height = '0;
		out_stall = 1'b0;
		in_taken = 1'b0;
		issued_cnt = 0;
		accepted_cnt = 0;
		err_cnt = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		atlas_w = 1024;
		atlas_h = 1024;
		table_reinit();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests on the reset atlas.
		queue_req(OP_ALLOC, 5, 0, 4);
		queue_req(OP_ALLOC, 5, 4, 0);
		queue_req(OP_ALLOC, 0, 4, 4);
		queue_req(OP_ALLOC, 5, 1025, 1);
		queue_req(OP_FREE, 0, 0, 0);
		queue_req(OP_FREE, 9999, 0, 0);
		queue_req(OP_ALLOC, 1, 1024, 1024);
		queue_req(OP_ALLOC, 2, 1, 1);
		queue_req(OP_FREE, 1, 0, 0);
		queue_req(OP_ALLOC, 3, 1022, 1023);
		queue_req(OP_FREE, 3, 0, 0);
		queue_req(OP_ALLOC, 65535, 16384, 16384);
		queue_req(OP_ALLOC, 32767, 32767, 32767);
		queue_req(OP_ALLOC, 16'hAAAA, 100, 10);
		queue_req(OP_ALLOC, 16'h5555, 10, 700);
		queue_req(OP_ALLOC, 16'h5555, 1, 1);
		queue_req(OP_ALLOC, 16'h8000, 1, 1);
		queue_req(OP_FREE, 16'h5555, 0, 0);
		queue_req(OP_FREE, 16'h5555, 0, 0);
		queue_req(OP_FREE, 16'hAAAA, 0, 0);
		queue_req(OP_FREE, 16'h8000, 0, 0);
		queue_req(OP_FREE, 16'hFFFF, 32767, 32767);
		drain();

		// Random phases, each on its own atlas size; the idling and stall patterns repeat every four phases.
		for (int p = 0; p < 8; p++) begin
			write_reg(CFG_ATLAS_W, sizes_w[p]);
			write_reg(CFG_ATLAS_H, sizes_h[p]);
			send_idle_pct = send_mode[p % 4];
			stall_pct = stall_mode[p % 4];
			for (int n = 0; n < 166; n++)
				queue_random();
			drain();
		end

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run time limit.
	initial begin
		#40000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
